### hdl/trtcm_pkg.sv
// Shared types and constants of the two-rate three-color meter.
package trtcm_pkg;

    localparam logic [1:0] CLR_GREEN  = 2'd0;
    localparam logic [1:0] CLR_YELLOW = 2'd1;
    localparam logic [1:0] CLR_RED    = 2'd2;

    localparam logic CMD_EXECUTE   = 1'b0;
    localparam logic CMD_CONFIGURE = 1'b1;

    localparam logic REG_BYTE_MODE = 1'b0;

    localparam logic BKT_PEAK   = 1'b0;
    localparam logic BKT_COMMIT = 1'b1;

    // divider retires two quotient bits per cycle
    localparam int DIV_CYCLES = 32;
    // four 32x32 partial products, then a final accumulate
    localparam int MUL_CYCLES = 4;

    typedef struct packed {
        logic [63:0] peak_period;
        logic [63:0] peak_units;
        logic [63:0] commit_period;
        logic [63:0] commit_units;
        logic [63:0] peak_burst;
        logic [63:0] commit_burst;
        logic [63:0] peak_tokens;
        logic [63:0] commit_tokens;
        logic [63:0] peak_time;
        logic [63:0] commit_time;
    } t_entry;

    typedef struct packed {
        logic [63:0] peak_period;
        logic [63:0] peak_units;
        logic [63:0] commit_period;
        logic [63:0] commit_units;
        logic [63:0] peak_burst;
        logic [63:0] commit_burst;
    } t_cfg;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_READ  = 12'b0000_0000_0100,
        S_LOAD  = 12'b0000_0000_1000,
        S_DSET  = 12'b0000_0001_0000,
        S_DIV   = 12'b0000_0010_0000,
        S_MUL   = 12'b0000_0100_0000,
        S_ADD   = 12'b0000_1000_0000,
        S_CAP   = 12'b0001_0000_0000,
        S_MARK  = 12'b0010_0000_0000,
        S_WRITE = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

endpackage

### hdl/two_rate_three_color_meter.sv
// Two-rate three-color meter table with an iterative refill datapath.
//
// Input channel: i_in_valid / o_in_stall carry one item, either an execute
// (mark a packet) or a configure (load a meter entry). Output channel:
// o_out_valid / i_out_stall carry one result item per input item.
// The block works on one item at a time and stalls its input meanwhile.
// An execute on a configured entry goes through the entry read, then per
// bucket a setup step, the shared radix-4 divider (elapsed time by period),
// the shared 32x32 multiplier (periods times units), add and cap; then mark
// and write back. With a zero committed period the second bucket skips the
// divider and multiplier. A configure reads, loads and writes back the
// entry; an execute on an unconfigured entry only reads and loads it; an
// index beyond the table goes straight to the output.
// After reset the table is cleared one entry per cycle, all NUM_METERS
// entries, with the input stalled; APB writes are taken throughout.
// A finished result waits in the output register while the next item is
// taken; the block holds its own result only if that register is still
// stalled when it finishes.
module two_rate_three_color_meter #(
    parameter int NUM_METERS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [9:0]  i_meter_index,
    input  logic [15:0] i_packet_length,
    input  logic [63:0] i_timestamp,
    input  logic [1:0]  i_color_in,
    input  logic        i_color_aware,
    input  logic [63:0] i_peak_period_in,
    input  logic [63:0] i_peak_units_in,
    input  logic [63:0] i_commit_period_in,
    input  logic [63:0] i_commit_units_in,
    input  logic [63:0] i_peak_burst_in,
    input  logic [63:0] i_commit_burst_in,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_color,
    output logic        o_entry_configured
);

    localparam int AW = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;

    trtcm_pkg::t_state r_state, n_state;

    trtcm_pkg::t_entry r_mem [NUM_METERS];
    trtcm_pkg::t_entry r_rd;
    trtcm_pkg::t_entry w_wdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr;

    logic          r_byte_mode;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_addr;
    logic          r_cmd;
    logic [15:0]   r_len;
    logic [63:0]   r_now;
    logic [1:0]    r_pre;
    logic          r_aware;
    trtcm_pkg::t_cfg r_cfg;

    logic          r_bkt;
    logic [4:0]    r_cnt;
    logic [63:0]   r_rem;
    logic [63:0]   r_quo;
    logic [63:0]   r_pp;
    logic [127:0]  r_acc;
    logic [63:0]   r_sum;
    logic [63:0]   r_ptok, r_ctok;
    logic [63:0]   r_ptime, r_ctime;
    logic [1:0]    r_res_color;
    logic          r_res_cfgd;

    logic          r_out_valid;
    logic [1:0]    r_o_color;
    logic          r_o_cfgd;

    logic [63:0]   w_period, w_units, w_when, w_left, w_burst;
    logic [63:0]   n_rem, n_quo;
    logic [64:0]   d_t;
    logic [31:0]   m_a, m_b;
    logic [63:0]   w_pp;
    logic [127:0]  w_pp_sh;
    logic [63:0]   w_prod;
    logic [64:0]   w_sum;
    logic [63:0]   w_mlen;
    logic          w_red, w_yellow;
    logic          w_in_range;
    logic          w_cfg_wr;
    logic          w_out_free;

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == trtcm_pkg::REG_BYTE_MODE) ? {31'd0, r_byte_mode} : 32'd0;
    assign w_cfg_wr   = psel & penable & pwrite & pready;
    assign o_in_stall = (r_state != trtcm_pkg::S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_color            = r_o_color;
    assign o_entry_configured = r_o_cfgd;
    assign w_in_range = (32'(i_meter_index) < NUM_METERS);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_mode <= 1'b1;
        end else if (w_cfg_wr && paddr[2] == trtcm_pkg::REG_BYTE_MODE) begin
            r_byte_mode <= pwdata[0];
        end
    end

    // bucket operand select
    always_comb begin
        if (r_bkt == trtcm_pkg::BKT_COMMIT) begin
            w_period = r_rd.commit_period;
            w_units  = r_rd.commit_units;
            w_when   = r_rd.commit_time;
            w_left   = r_rd.commit_tokens;
            w_burst  = r_rd.commit_burst;
        end else begin
            w_period = r_rd.peak_period;
            w_units  = r_rd.peak_units;
            w_when   = r_rd.peak_time;
            w_left   = r_rd.peak_tokens;
            w_burst  = r_rd.peak_burst;
        end
    end

    // two restoring division steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        d_t   = 65'd0;
        for (int k = 0; k < 2; k++) begin
            d_t   = {n_rem, n_quo[63]};
            n_quo = {n_quo[62:0], 1'b0};
            if (d_t >= {1'b0, w_period}) begin
                d_t      = d_t - {1'b0, w_period};
                n_quo[0] = 1'b1;
            end
            n_rem = d_t[63:0];
        end
    end

    // partial products of quotient times units
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin m_a = r_quo[31:0];  m_b = w_units[31:0];  end
            2'd1: begin m_a = r_quo[31:0];  m_b = w_units[63:32]; end
            2'd2: begin m_a = r_quo[63:32]; m_b = w_units[31:0];  end
            default: begin m_a = r_quo[63:32]; m_b = w_units[63:32]; end
        endcase
        w_pp = 64'(m_a) * 64'(m_b);
        if (r_cnt == 5'd1) begin
            w_pp_sh = 128'(r_pp);
        end else if (r_cnt == 5'(trtcm_pkg::MUL_CYCLES)) begin
            w_pp_sh = {r_pp, 64'd0};
        end else begin
            w_pp_sh = {32'd0, r_pp, 32'd0};
        end
    end

    assign w_prod = (|r_acc[127:64]) ? '1 : r_acc[63:0];
    assign w_sum  = {1'b0, w_left} + {1'b0, w_prod};
    assign w_mlen = r_byte_mode ? 64'(r_len) : 64'd1;
    assign w_red    = (r_aware && r_pre == trtcm_pkg::CLR_RED) || (w_mlen > r_ptok);
    assign w_yellow = (r_aware && r_pre == trtcm_pkg::CLR_YELLOW) || (w_mlen > r_ctok);

    // table write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_rd;
        if (r_state == trtcm_pkg::S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == trtcm_pkg::S_WRITE) begin
            w_we = 1'b1;
            if (r_cmd == trtcm_pkg::CMD_CONFIGURE) begin
                w_wdata.peak_period   = r_cfg.peak_period;
                w_wdata.peak_units    = r_cfg.peak_units;
                w_wdata.commit_period = r_cfg.commit_period;
                w_wdata.commit_units  = r_cfg.commit_units;
                w_wdata.peak_burst    = r_cfg.peak_burst;
                w_wdata.commit_burst  = r_cfg.commit_burst;
                w_wdata.peak_tokens   = r_cfg.peak_burst;
                w_wdata.commit_tokens = r_cfg.commit_burst;
                w_wdata.peak_time     = r_now;
                w_wdata.commit_time   = r_now;
            end else begin
                w_wdata.peak_tokens   = r_ptok;
                w_wdata.commit_tokens = r_ctok;
                w_wdata.peak_time     = r_ptime;
                w_wdata.commit_time   = r_ctime;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == trtcm_pkg::S_READ) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            trtcm_pkg::S_CLEAR: begin
                if (r_clr == AW'(NUM_METERS - 1)) n_state = trtcm_pkg::S_IDLE;
            end
            trtcm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = w_in_range ? trtcm_pkg::S_READ : trtcm_pkg::S_OUT;
            end
            trtcm_pkg::S_READ: n_state = trtcm_pkg::S_LOAD;
            trtcm_pkg::S_LOAD: begin
                if (r_cmd == trtcm_pkg::CMD_CONFIGURE) begin
                    n_state = trtcm_pkg::S_WRITE;
                end else if (r_rd.peak_period == 64'd0) begin
                    n_state = trtcm_pkg::S_OUT;
                end else begin
                    n_state = trtcm_pkg::S_DSET;
                end
            end
            trtcm_pkg::S_DSET: begin
                n_state = (w_period == 64'd0) ? trtcm_pkg::S_ADD : trtcm_pkg::S_DIV;
            end
            trtcm_pkg::S_DIV: begin
                if (r_cnt == 5'(trtcm_pkg::DIV_CYCLES - 1)) n_state = trtcm_pkg::S_MUL;
            end
            trtcm_pkg::S_MUL: begin
                if (r_cnt == 5'(trtcm_pkg::MUL_CYCLES)) n_state = trtcm_pkg::S_ADD;
            end
            trtcm_pkg::S_ADD: n_state = trtcm_pkg::S_CAP;
            trtcm_pkg::S_CAP: begin
                n_state = (r_bkt == trtcm_pkg::BKT_PEAK) ? trtcm_pkg::S_DSET
                                                         : trtcm_pkg::S_MARK;
            end
            trtcm_pkg::S_MARK:  n_state = trtcm_pkg::S_WRITE;
            trtcm_pkg::S_WRITE: n_state = trtcm_pkg::S_OUT;
            trtcm_pkg::S_OUT: begin
                if (w_out_free) n_state = trtcm_pkg::S_IDLE;
            end
            default: n_state = trtcm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trtcm_pkg::S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_bkt       <= trtcm_pkg::BKT_PEAK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == trtcm_pkg::S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                trtcm_pkg::S_CLEAR: r_clr <= r_clr + AW'(1);
                trtcm_pkg::S_LOAD:  r_bkt <= trtcm_pkg::BKT_PEAK;
                trtcm_pkg::S_DSET:  r_cnt <= '0;
                trtcm_pkg::S_DIV: begin
                    r_cnt <= (r_cnt == 5'(trtcm_pkg::DIV_CYCLES - 1)) ? 5'd0 : r_cnt + 5'd1;
                end
                trtcm_pkg::S_MUL:   r_cnt <= r_cnt + 5'd1;
                trtcm_pkg::S_CAP:   r_bkt <= trtcm_pkg::BKT_COMMIT;
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            trtcm_pkg::S_IDLE: begin
                r_cmd       <= i_command;
                r_addr      <= AW'(i_meter_index);
                r_len       <= i_packet_length;
                r_now       <= i_timestamp;
                r_pre       <= i_color_in;
                r_aware     <= i_color_aware;
                r_cfg.peak_period   <= i_peak_period_in;
                r_cfg.peak_units    <= i_peak_units_in;
                r_cfg.commit_period <= i_commit_period_in;
                r_cfg.commit_units  <= i_commit_units_in;
                r_cfg.peak_burst    <= i_peak_burst_in;
                r_cfg.commit_burst  <= i_commit_burst_in;
                r_res_color <= trtcm_pkg::CLR_GREEN;
                r_res_cfgd  <= 1'b0;
            end
            trtcm_pkg::S_LOAD: begin
                r_res_cfgd <= (r_rd.peak_period != 64'd0);
            end
            trtcm_pkg::S_DSET: begin
                r_acc <= '0;
                r_rem <= '0;
                r_quo <= r_now - w_when;
                if (w_period == 64'd0) begin
                    if (r_bkt == trtcm_pkg::BKT_COMMIT) r_ctime <= w_when;
                    else r_ptime <= w_when;
                end
            end
            trtcm_pkg::S_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
            end
            trtcm_pkg::S_MUL: begin
                if (r_cnt == 5'd0) begin
                    // last refill instant: now less the leftover part of a period
                    if (r_bkt == trtcm_pkg::BKT_COMMIT) r_ctime <= r_now - r_rem;
                    else r_ptime <= r_now - r_rem;
                end
                if (r_cnt < 5'(trtcm_pkg::MUL_CYCLES)) r_pp <= w_pp;
                if (r_cnt != 5'd0) r_acc <= r_acc + w_pp_sh;
            end
            trtcm_pkg::S_ADD: begin
                r_sum <= w_sum[64] ? '1 : w_sum[63:0];
            end
            trtcm_pkg::S_CAP: begin
                if (r_bkt == trtcm_pkg::BKT_COMMIT) begin
                    r_ctok <= (r_sum > w_burst) ? w_burst : r_sum;
                end else begin
                    r_ptok <= (r_sum > w_burst) ? w_burst : r_sum;
                end
            end
            trtcm_pkg::S_MARK: begin
                if (w_red) begin
                    r_res_color <= trtcm_pkg::CLR_RED;
                end else if (w_yellow) begin
                    r_res_color <= trtcm_pkg::CLR_YELLOW;
                    r_ptok      <= r_ptok - w_mlen;
                end else begin
                    r_res_color <= trtcm_pkg::CLR_GREEN;
                    r_ptok      <= r_ptok - w_mlen;
                    r_ctok      <= r_ctok - w_mlen;
                end
            end
            trtcm_pkg::S_OUT: begin
                if (w_out_free) begin
                    r_o_color <= r_res_color;
                    r_o_cfgd  <= r_res_cfgd;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### test/tb_two_rate_three_color_meter.sv
// Self-checking testbench of the two-rate three-color meter table.
`timescale 1ns / 1ps

module tb_two_rate_three_color_meter;

    localparam logic [63:0] MAX64          = '1;
    localparam logic [63:0] NIL64          = 64'd0;
    localparam logic [1:0]  CLR_UNUSED     = 2'd3;
    localparam logic [2:0]  BYTE_MODE_ADDR = {trtcm_pkg::REG_BYTE_MODE, 2'b00};
    localparam int          POOL_SIZE      = 16;
    localparam int          PHASE_ITEMS    = 220;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  idx;
        logic [15:0] len;
        logic [63:0] ts;
        logic [1:0]  cin;
        logic        aware;
        logic [63:0] pp;
        logic [63:0] pu;
        logic [63:0] cp;
        logic [63:0] cu;
        logic [63:0] pb;
        logic [63:0] cb;
    } t_meter_item;

    typedef struct packed {
        logic [1:0] color;
        logic       cfgd;
    } t_mark;

    typedef struct packed {
        t_meter_item item;
        logic        typed;
        t_mark       want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = 1'b0;
    logic [9:0]  i_meter_index = '0;
    logic [15:0] i_packet_length = '0;
    logic [63:0] i_timestamp = '0;
    logic [1:0]  i_color_in = '0;
    logic        i_color_aware = 1'b0;
    logic [63:0] i_peak_period_in = '0;
    logic [63:0] i_peak_units_in = '0;
    logic [63:0] i_commit_period_in = '0;
    logic [63:0] i_commit_units_in = '0;
    logic [63:0] i_peak_burst_in = '0;
    logic [63:0] i_commit_burst_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_color;
    logic        o_entry_configured;

    trtcm_pkg::t_entry meters [1024];
    logic        bytes_metered = 1'b1;
    t_mark       mark_q [$];
    int          errors = 0;
    int          sink_wait = 0;
    bit          no_idle = 1'b0;
    int          pool [POOL_SIZE];
    logic [63:0] t_now = '0;

    t_dir_row directed_rows [0:21] = '{
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd0, 16'd0, 64'd0, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b1, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd1023, 16'hFFFF, MAX64, trtcm_pkg::CLR_RED, 1'b1,
            MAX64, MAX64, MAX64, MAX64, MAX64, MAX64},
          1'b1, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_CONFIGURE, 10'd5, 16'd0, 64'd1000, trtcm_pkg::CLR_GREEN, 1'b0,
            64'd10, 64'd100, 64'd20, 64'd50, 64'd1000, 64'd500},
          1'b1, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_CONFIGURE, 10'd5, 16'd0, 64'd1000, trtcm_pkg::CLR_GREEN, 1'b0,
            64'd10, 64'd100, 64'd20, 64'd50, 64'd1000, 64'd500},
          1'b1, '{trtcm_pkg::CLR_GREEN, 1'b1}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd5, 16'd400, 64'd1000, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd5, 16'd200, 64'd1000, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd5, 16'd500, 64'd1000, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd5, 16'd0, 64'd1000, trtcm_pkg::CLR_RED, 1'b1,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd5, 16'd0, 64'd1000, trtcm_pkg::CLR_YELLOW, 1'b1,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd5, 16'd0, 64'd1000, CLR_UNUSED, 1'b1,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd5, 16'd0, 64'd1100, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd5, 16'd1000, 64'd1105, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_CONFIGURE, 10'd7, 16'd0, 64'd0, trtcm_pkg::CLR_GREEN, 1'b0,
            64'd1, MAX64, 64'd0, MAX64, MAX64, 64'd3},
          1'b1, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd7, 16'hFFFF, MAX64, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd7, 16'd4, 64'd5, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_CONFIGURE, 10'd9, 16'd0, 64'd50, trtcm_pkg::CLR_GREEN, 1'b0,
            64'd0, 64'd1, 64'd1, 64'd1, 64'd1, 64'd1},
          1'b1, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd9, 16'd1, 64'd60, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b1, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_CONFIGURE, 10'd1023, 16'd0, MAX64, trtcm_pkg::CLR_GREEN, 1'b0,
            MAX64, MAX64, MAX64, MAX64, MAX64, MAX64},
          1'b1, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd1023, 16'hFFFF, 64'd0, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_CONFIGURE, 10'd0, 16'd0, 64'd0, trtcm_pkg::CLR_GREEN, 1'b0,
            MAX64, 64'd0, MAX64, 64'd0, 64'd0, 64'd0},
          1'b1, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd0, 16'd0, MAX64, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}},
        '{'{trtcm_pkg::CMD_EXECUTE, 10'd0, 16'd1, MAX64, trtcm_pkg::CLR_GREEN, 1'b0,
            NIL64, NIL64, NIL64, NIL64, NIL64, NIL64},
          1'b0, '{trtcm_pkg::CLR_GREEN, 1'b0}}
    };

    two_rate_three_color_meter uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_meter_index      (i_meter_index),
        .i_packet_length    (i_packet_length),
        .i_timestamp        (i_timestamp),
        .i_color_in         (i_color_in),
        .i_color_aware      (i_color_aware),
        .i_peak_period_in   (i_peak_period_in),
        .i_peak_units_in    (i_peak_units_in),
        .i_commit_period_in (i_commit_period_in),
        .i_commit_units_in  (i_commit_units_in),
        .i_peak_burst_in    (i_peak_burst_in),
        .i_commit_burst_in  (i_commit_burst_in),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_color            (o_color),
        .o_entry_configured (o_entry_configured)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // whole-period refill with saturating product and sum, then burst cap
    function automatic logic [63:0] refill_bucket(input logic [63:0] now, input logic [63:0] last,
                                                  input logic [63:0] period,
                                                  input logic [63:0] units,
                                                  input logic [63:0] left,
                                                  input logic [63:0] burst,
                                                  output logic [63:0] next_last);
        logic [63:0]  periods;
        logic [127:0] prod;
        logic [63:0]  gain;
        logic [64:0]  sum;
        logic [63:0]  tok;
        periods   = '0;
        next_last = last;
        if (period != 0) begin
            periods   = (now - last) / period;
            next_last = last + periods * period;
        end
        prod = {64'd0, periods} * {64'd0, units};
        gain = (prod[127:64] != 0) ? MAX64 : prod[63:0];
        sum  = {1'b0, left} + {1'b0, gain};
        tok  = sum[64] ? MAX64 : sum[63:0];
        return (tok > burst) ? burst : tok;
    endfunction

    function automatic t_mark mark_packet(input t_meter_item it);
        t_mark             r;
        trtcm_pkg::t_entry e;
        logic [63:0]       cost;
        logic [63:0]       tp;
        logic [63:0]       tc;
        logic [63:0]       nl;
        r.color = trtcm_pkg::CLR_GREEN;
        e = meters[it.idx];
        r.cfgd = (e.peak_period != 0);
        if (it.cmd == trtcm_pkg::CMD_CONFIGURE) begin
            e.peak_period   = it.pp;
            e.peak_units    = it.pu;
            e.commit_period = it.cp;
            e.commit_units  = it.cu;
            e.peak_burst    = it.pb;
            e.commit_burst  = it.cb;
            e.peak_tokens   = it.pb;
            e.commit_tokens = it.cb;
            e.peak_time     = it.ts;
            e.commit_time   = it.ts;
            meters[it.idx]  = e;
            return r;
        end
        if (e.peak_period == 0)
            return r;
        cost = bytes_metered ? {48'd0, it.len} : 64'd1;
        tp = refill_bucket(it.ts, e.peak_time, e.peak_period, e.peak_units,
                           e.peak_tokens, e.peak_burst, nl);
        e.peak_time = nl;
        tc = refill_bucket(it.ts, e.commit_time, e.commit_period, e.commit_units,
                           e.commit_tokens, e.commit_burst, nl);
        e.commit_time = nl;
        if ((it.aware && it.cin == trtcm_pkg::CLR_RED) || cost > tp) begin
            r.color = trtcm_pkg::CLR_RED;
        end else if ((it.aware && it.cin == trtcm_pkg::CLR_YELLOW) || cost > tc) begin
            r.color = trtcm_pkg::CLR_YELLOW;
            tp -= cost;
        end else begin
            tp -= cost;
            tc -= cost;
        end
        e.peak_tokens   = tp;
        e.commit_tokens = tc;
        meters[it.idx]  = e;
        return r;
    endfunction

    // sane rates for the current metering mode, so that all three colors show up
    function automatic t_meter_item meter_setup(input int idx);
        t_meter_item it;
        it.cmd   = trtcm_pkg::CMD_CONFIGURE;
        it.idx   = idx[9:0];
        it.len   = 16'($urandom);
        it.ts    = t_now;
        it.cin   = 2'($urandom_range(0, 3));
        it.aware = 1'($urandom_range(0, 1));
        if (bytes_metered) begin
            it.pp = 64'($urandom_range(1, 60));
            it.pu = 64'($urandom_range(0, 400));
            it.cp = ($urandom_range(0, 7) == 0) ? 64'd0 : 64'($urandom_range(1, 120));
            it.cu = 64'($urandom_range(0, 200));
            it.pb = 64'($urandom_range(0, 5000));
            it.cb = 64'($urandom_range(0, 2500));
        end else begin
            it.pp = 64'($urandom_range(50, 400));
            it.pu = 64'($urandom_range(0, 2));
            it.cp = ($urandom_range(0, 7) == 0) ? 64'd0 : 64'($urandom_range(50, 800));
            it.cu = 64'($urandom_range(0, 1));
            it.pb = 64'($urandom_range(0, 6));
            it.cb = 64'($urandom_range(0, 3));
        end
        return it;
    endfunction

    function automatic t_meter_item draw_item();
        t_meter_item it;
        int          kind;
        kind  = $urandom_range(0, 99);
        t_now = t_now + 64'($urandom_range(0, 400));
        if (kind < 14)
            return meter_setup(pool[$urandom_range(0, POOL_SIZE - 1)]);
        it.cmd   = trtcm_pkg::CMD_EXECUTE;
        it.idx   = 10'(pool[$urandom_range(0, POOL_SIZE - 1)]);
        it.ts    = t_now;
        it.cin   = 2'($urandom_range(0, 3));
        it.aware = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
            it.len = 16'($urandom);
        else
            it.len = bytes_metered ? 16'($urandom_range(0, 1500)) : 16'($urandom_range(0, 3));
        it.pp = rand64();
        it.pu = rand64();
        it.cp = rand64();
        it.cu = rand64();
        it.pb = rand64();
        it.cb = rand64();
        if (kind < 20) begin
            // arbitrary entry contents, often a disabled entry
            it.cmd = trtcm_pkg::CMD_CONFIGURE;
            it.idx = 10'($urandom_range(0, 1023));
            it.ts  = rand64();
            if ($urandom_range(0, 1) == 0)
                it.pp = 64'd0;
        end else if (kind < 32) begin
            it.idx = 10'($urandom_range(0, 1023));
            it.len = 16'($urandom);
            if (kind < 26)
                it.ts = rand64();
        end
        return it;
    endfunction

    task automatic send_item(input t_meter_item it, input bit typed, input t_mark want);
        int    gap;
        t_mark got;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command          <= it.cmd;
        i_meter_index      <= it.idx;
        i_packet_length    <= it.len;
        i_timestamp        <= it.ts;
        i_color_in         <= it.cin;
        i_color_aware      <= it.aware;
        i_peak_period_in   <= it.pp;
        i_peak_units_in    <= it.pu;
        i_commit_period_in <= it.cp;
        i_commit_units_in  <= it.cu;
        i_peak_burst_in    <= it.pb;
        i_commit_burst_in  <= it.cb;
        i_in_valid         <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        got = mark_packet(it);
        mark_q = {mark_q, (typed ? want : got)};
    endtask

    task automatic wait_all_marked();
        i_in_valid <= 1'b0;
        while (mark_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= BYTE_MODE_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_byte_mode(input logic bm);
        logic [31:0] rd;
        apb_access(1'b0, 32'd0, rd);
        if (rd !== {31'd0, bm}) begin
            $display("%0t: byte_mode readback expected %0h got %0h", $time, bm, rd);
            errors++;
        end
    endtask

    task automatic set_byte_mode(input logic bm);
        logic [31:0] rd;
        apb_access(1'b1, {31'd0, bm}, rd);
        bytes_metered = bm;
        check_byte_mode(bm);
    endtask

    always @(posedge i_clk) begin : result_sink
        t_mark want;
        int    hold;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            sink_wait   <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (mark_q.size() == 0) begin
                $display("%0t: unexpected result color %0d configured %0d",
                         $time, o_color, o_entry_configured);
                errors++;
            end else begin
                want = mark_q.pop_front();
                if (o_color !== want.color) begin
                    $display("%0t: color expected %0d got %0d", $time, want.color, o_color);
                    errors++;
                end
                if (o_entry_configured !== want.cfgd) begin
                    $display("%0t: entry_configured expected %0d got %0d",
                             $time, want.cfgd, o_entry_configured);
                    errors++;
                end
            end
            hold = no_idle ? 0 : $urandom_range(0, 11);
            sink_wait   <= hold;
            i_out_stall <= (hold != 0);
        end else if (sink_wait != 0) begin
            sink_wait   <= sink_wait - 1;
            i_out_stall <= (sink_wait > 1);
        end
    end

    initial begin : stimulus
        int k;
        int phase;
        for (k = 0; k < 1024; k++)
            meters[k] = '0;
        t_now = rand64();
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_byte_mode(1'b1);
        set_byte_mode(1'b1);
        for (k = 0; k < 22; k++)
            send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
        wait_all_marked();

        for (phase = 0; phase < 4; phase++) begin
            set_byte_mode(phase[0]);
            for (k = 0; k < POOL_SIZE; k++)
                pool[k] = (k == 0) ? 0 : (k == POOL_SIZE - 1) ? 1023 : $urandom_range(0, 1023);
            for (k = 0; k < POOL_SIZE; k++)
                send_item(meter_setup(pool[k]), 1'b0, '0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_item(draw_item(), 1'b0, '0);
            end
            no_idle = 1'b0;
            wait_all_marked();
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0 && mark_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
